[rtl/core/irpw_pkg.sv]
// ----------------------------------------------------------------------------
// irpw_pkg
// Shared types and timing windows for the IR pulse-width frame decoder.
// ----------------------------------------------------------------------------
package irpw_pkg;

  // Timing windows in 4 MHz ticks.
  localparam logic [15:0] LEAD_LOW_MIN   = 16'd28000;
  localparam logic [15:0] LEAD_LOW_MAX   = 16'd40000;
  localparam logic [15:0] LEAD_PER_MIN   = 16'd48000;
  localparam logic [15:0] LEAD_PER_MAX   = 16'd60000;
  localparam logic [15:0] RPT_PER_MIN    = 16'd40000;
  localparam logic [15:0] RPT_PER_MAX    = 16'd47999;
  localparam logic [15:0] BIT_LOW_MIN    = 16'd1600;
  localparam logic [15:0] BIT_LOW_MAX    = 16'd3200;
  localparam logic [15:0] ZERO_PER_MIN   = 16'd3200;
  localparam logic [15:0] ZERO_PER_MAX   = 16'd6400;
  localparam logic [15:0] ONE_PER_MIN    = 16'd6401;
  localparam logic [15:0] ONE_PER_MAX    = 16'd12000;

  localparam logic [3:0]  RPT_THR_RESET  = 4'd4;
  localparam logic [3:0]  RPT_COUNT_MAX  = 4'd15;
  localparam logic [2:0]  LAST_BIT       = 3'd7;
  localparam logic [1:0]  LAST_BYTE      = 2'd3;

  typedef logic [3:0][7:0] frame_t;

  // Decoder state carried from one pulse to the next.
  typedef struct packed {
    logic       first_seen;
    logic       receiving;
    logic [1:0] byte_index;
    logic [2:0] bit_count;
    logic [3:0] repeat_count;
    frame_t     assembly;
    frame_t     last_frame;
  } state_t;

  // Outcome of one pulse.
  typedef struct packed {
    logic   emit;
    logic   is_repeat;
    frame_t frame;
  } result_t;

  function automatic logic in_rng(input logic [15:0] v, input logic [15:0] lo,
                                  input logic [15:0] hi);
    in_rng = (v >= lo) && (v <= hi);
  endfunction

endpackage

[rtl/core/irpw_step.sv]
// ----------------------------------------------------------------------------
// irpw_step
// Classifies one pulse and computes the next decoder state and any result.
// ----------------------------------------------------------------------------
module irpw_step (
  input  irpw_pkg::state_t  st,
  input  logic [15:0]       period,
  input  logic [15:0]       low,
  input  logic [3:0]        threshold,
  output irpw_pkg::state_t  st_nxt,
  output irpw_pkg::result_t res
);

  logic lead_low;
  logic bit_low;
  logic is_leader;
  logic is_rpt;
  logic is_zero;
  logic is_one;
  irpw_pkg::frame_t filled;

  always_comb begin
    lead_low  = irpw_pkg::in_rng(low, irpw_pkg::LEAD_LOW_MIN, irpw_pkg::LEAD_LOW_MAX);
    bit_low   = irpw_pkg::in_rng(low, irpw_pkg::BIT_LOW_MIN, irpw_pkg::BIT_LOW_MAX);
    is_leader = lead_low &&
                irpw_pkg::in_rng(period, irpw_pkg::LEAD_PER_MIN, irpw_pkg::LEAD_PER_MAX);
    is_rpt    = lead_low &&
                irpw_pkg::in_rng(period, irpw_pkg::RPT_PER_MIN, irpw_pkg::RPT_PER_MAX);
    is_zero   = bit_low &&
                irpw_pkg::in_rng(period, irpw_pkg::ZERO_PER_MIN, irpw_pkg::ZERO_PER_MAX);
    is_one    = bit_low &&
                irpw_pkg::in_rng(period, irpw_pkg::ONE_PER_MIN, irpw_pkg::ONE_PER_MAX);

    // Assembly with the current bit merged in, MSB first.
    filled = st.assembly;
    filled[st.byte_index][irpw_pkg::LAST_BIT - st.bit_count] =
      filled[st.byte_index][irpw_pkg::LAST_BIT - st.bit_count] | is_one;

    st_nxt        = st;
    res.emit      = 1'b0;
    res.is_repeat = 1'b0;
    res.frame     = st.last_frame;

    if (!st.first_seen) begin
      st_nxt.first_seen = 1'b1;
    end else if (!st.receiving) begin
      if (is_leader) begin
        st_nxt.receiving    = 1'b1;
        st_nxt.byte_index   = '0;
        st_nxt.bit_count    = '0;
        st_nxt.repeat_count = '0;
        st_nxt.assembly     = '0;
      end else if (is_rpt) begin
        if (st.repeat_count > threshold) begin
          st_nxt.repeat_count = threshold + 4'd1;
          res.emit            = 1'b1;
          res.is_repeat       = 1'b1;
        end else if (st.repeat_count < irpw_pkg::RPT_COUNT_MAX) begin
          st_nxt.repeat_count = st.repeat_count + 4'd1;
        end
      end
    end else if (is_zero || is_one) begin
      st_nxt.assembly  = filled;
      st_nxt.bit_count = st.bit_count + 3'd1;
      if (st.bit_count == irpw_pkg::LAST_BIT) begin
        st_nxt.byte_index = st.byte_index + 2'd1;
        if (st.byte_index == irpw_pkg::LAST_BYTE) begin
          // Fourth byte closed: the frame is complete.
          res.emit          = 1'b1;
          res.frame         = filled;
          st_nxt.last_frame = filled;
          st_nxt.assembly   = '0;
          st_nxt.receiving  = 1'b0;
        end
      end
    end else begin
      st_nxt.receiving = 1'b0;
    end
  end

endmodule

[rtl/core/ir_pulse_width_frame_decoder_core.sv]
// ----------------------------------------------------------------------------
// ir_pulse_width_frame_decoder_core
// NEC-style infrared frame decoder working on measured pulse widths.
// ----------------------------------------------------------------------------
// Each input beat carries one measured pulse (period and low time in 4 MHz
// ticks) and the block takes one beat per clock cycle when the result side is
// not holding it back. A beat is captured in an input register, decoded from
// there against the decoder state, and any result is loaded into the output
// register; a result beat thus passes through both registers. The first
// pulse after reset is discarded. A leader pulse opens a frame, 32 bit
// pulses fill it MSB first into four bytes, and the finished frame is
// delivered with is_repeat low. Repeat pulses are counted while idle; once
// the count exceeds repeat_threshold every further repeat pulse delivers the
// last frame again with is_repeat high. Any pulse outside the bit windows
// during a frame drops back to idle without a result. repeat_threshold
// resets to 4 and should only be written while no pulse is in flight.
module ir_pulse_width_frame_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_period_ticks,
  input  logic [15:0] in_low_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte0,
  output logic [7:0]  out_frame_byte1,
  output logic [7:0]  out_frame_byte2,
  output logic [7:0]  out_frame_byte3,
  output logic        out_is_repeat
);

  logic [3:0]        threshold_r;
  logic              s1_valid_r;
  logic [15:0]       s1_period_r;
  logic [15:0]       s1_low_r;
  irpw_pkg::state_t  st_r;
  irpw_pkg::state_t  st_nxt;
  irpw_pkg::result_t res;
  logic              out_valid_r;
  irpw_pkg::frame_t  out_frame_r;
  logic              out_is_repeat_r;
  logic              out_free;
  logic              proc;
  logic              s1_take;

  irpw_step u_step (
    .st        (st_r),
    .period    (s1_period_r),
    .low       (s1_low_r),
    .threshold (threshold_r),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  // The held pulse is decoded once the result register can accept its
  // outcome; pulses that yield nothing never wait on the output side.
  assign out_free = !out_valid_r || !out_stall;
  assign proc     = s1_valid_r && (!res.emit || out_free);
  assign in_stall = s1_valid_r && !proc;
  assign s1_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= irpw_pkg::RPT_THR_RESET;
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_take) begin
      s1_valid_r <= 1'b1;
    end else if (proc) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_period_r <= in_period_ticks;
      s1_low_r    <= in_low_ticks;
    end
  end

  // Decoder state, cleared on reset including both frame buffers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (proc) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res.emit) begin
      out_frame_r     <= res.frame;
      out_is_repeat_r <= res.is_repeat;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_byte0 = out_frame_r[0];
  assign out_frame_byte1 = out_frame_r[1];
  assign out_frame_byte2 = out_frame_r[2];
  assign out_frame_byte3 = out_frame_r[3];
  assign out_is_repeat   = out_is_repeat_r;

`ifndef SYNTHESIS
  // A completed fresh frame always leaves the decoder idle.
  a_frame_ends_rx: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && res.emit && !res.is_repeat) |=> !st_r.receiving)
    else $error("decoder still receiving after a complete frame");

  // Repeated frames only come out of the idle state.
  a_repeat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && res.emit && res.is_repeat) |-> !st_r.receiving)
    else $error("repeat frame emitted while receiving");

  // A frame can only be in progress after the discarded first pulse.
  a_rx_after_first: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.receiving |-> st_r.first_seen)
    else $error("receiving before first pulse was discarded");
`endif

endmodule

[bench/irpw_frame_checker.sv]
// ----------------------------------------------------------------------------
// irpw_frame_checker
// Watches both channels of the IR frame decoder, predicts every result beat
// from the accepted pulses and compares what the block delivers.
// ----------------------------------------------------------------------------
module irpw_frame_checker
  import irpw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] in_period_ticks,
  input  logic [15:0] in_low_ticks,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_frame_byte0,
  input  logic [7:0]  out_frame_byte1,
  input  logic [7:0]  out_frame_byte2,
  input  logic [7:0]  out_frame_byte3,
  input  logic        out_is_repeat,
  output int          mismatches,
  output int          frames_pending
);

  typedef struct packed {
    frame_t bytes;
    logic   is_repeat;
  } frame_beat_t;

  frame_beat_t expected_frames[$];

  logic [3:0] repeat_threshold;
  logic       seen_first;
  logic       in_frame;
  int         byte_pos;
  int         bit_pos;
  logic [3:0] held_repeats;
  frame_t     assembling;
  frame_t     last_frame;

  function automatic logic between(input logic [15:0] v, input logic [15:0] lo,
                                   input logic [15:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Advances the decoder state by one pulse and queues the frame it yields.
  task automatic decode_pulse(input logic [15:0] period, input logic [15:0] low);
    logic one_bit;
    if (!seen_first) begin
      seen_first = 1'b1;
      return;
    end
    if (!in_frame) begin
      if (!between(low, LEAD_LOW_MIN, LEAD_LOW_MAX))
        return;
      if (between(period, LEAD_PER_MIN, LEAD_PER_MAX)) begin
        in_frame     = 1'b1;
        byte_pos     = 0;
        bit_pos      = 0;
        held_repeats = '0;
        assembling   = '0;
      end else if (between(period, RPT_PER_MIN, RPT_PER_MAX)) begin
        if (held_repeats > repeat_threshold) begin
          held_repeats = repeat_threshold + 4'd1;
          expected_frames.push_back('{bytes: last_frame, is_repeat: 1'b1});
        end else if (held_repeats < 4'd15) begin
          held_repeats++;
        end
      end
      return;
    end
    if (between(low, BIT_LOW_MIN, BIT_LOW_MAX) &&
        between(period, ZERO_PER_MIN, ZERO_PER_MAX)) begin
      one_bit = 1'b0;
    end else if (between(low, BIT_LOW_MIN, BIT_LOW_MAX) &&
                 between(period, ONE_PER_MIN, ONE_PER_MAX)) begin
      one_bit = 1'b1;
    end else begin
      // Abort: the partial bits stay until the next leader.
      in_frame = 1'b0;
      return;
    end
    assembling[byte_pos][7 - bit_pos] = assembling[byte_pos][7 - bit_pos] | one_bit;
    if (bit_pos == 7) begin
      bit_pos = 0;
      byte_pos++;
    end else begin
      bit_pos++;
    end
    if (byte_pos == 4) begin
      expected_frames.push_back('{bytes: assembling, is_repeat: 1'b0});
      last_frame = assembling;
      assembling = '0;
      in_frame   = 1'b0;
      byte_pos   = 0;
      bit_pos    = 0;
    end
  endtask

  always @(posedge clk) begin : monitor
    frame_beat_t want;
    if (!rst_n) begin
      repeat_threshold = RPT_THR_RESET;
      seen_first       = 1'b0;
      in_frame         = 1'b0;
      byte_pos         = 0;
      bit_pos          = 0;
      held_repeats     = '0;
      assembling       = '0;
      last_frame       = '0;
      mismatches       = 0;
      expected_frames.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          $error("result beat with no frame expected: %h %h %h %h repeat %b",
                 out_frame_byte0, out_frame_byte1, out_frame_byte2, out_frame_byte3,
                 out_is_repeat);
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          check_field("frame_byte0", want.bytes[0], out_frame_byte0);
          check_field("frame_byte1", want.bytes[1], out_frame_byte1);
          check_field("frame_byte2", want.bytes[2], out_frame_byte2);
          check_field("frame_byte3", want.bytes[3], out_frame_byte3);
          check_field("is_repeat", {7'd0, want.is_repeat}, {7'd0, out_is_repeat});
        end
      end
      if (cfg_wr_en)
        repeat_threshold = cfg_wr_data;
      if (in_valid && !in_stall)
        decode_pulse(in_period_ticks, in_low_ticks);
    end
    frames_pending = expected_frames.size();
  end

endmodule

[bench/ir_pulse_width_frame_decoder_core_test.sv]
// ----------------------------------------------------------------------------
// ir_pulse_width_frame_decoder_core_test
// Drives measured pulses into the IR frame decoder and checks every frame.
// ----------------------------------------------------------------------------
// A short directed sequence covers the discarded first pulse, repeats before
// any frame, ignored idle pulses, the edges of every timing window and aborts
// that leave partial bits behind. Six random phases follow, each with its own
// repeat threshold, made mostly of complete frames and held-key repeat runs,
// mixed with broken frames and raw noise. A checker beside the block predicts
// and compares; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module ir_pulse_width_frame_decoder_core_test;
  import irpw_pkg::*;

  // Longest random wait on either side, in cycles.
  localparam int MAX_WAIT      = 18;
  // A pulse that yields no result leaves the input register in the cycle after
  // it is taken and never waits on the output side; a few spare cycles
  // are added anyway before the threshold is changed.
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_PULSES  = 200;
  localparam int NUM_PHASES    = 6;
  // Watchdog limit in time units, far above the slowest correct run.
  localparam int RUN_LIMIT     = 1_000_000;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_period_ticks;
  logic [15:0] in_low_ticks;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_frame_byte0;
  logic [7:0]  out_frame_byte1;
  logic [7:0]  out_frame_byte2;
  logic [7:0]  out_frame_byte3;
  logic        out_is_repeat;

  int          mismatches;
  int          frames_pending;
  int          pulses_sent;
  logic [3:0]  threshold_now;
  // When set, both sides run back to back for the current sequence.
  bit          no_idle;

  ir_pulse_width_frame_decoder_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_period_ticks (in_period_ticks),
    .in_low_ticks    (in_low_ticks),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_byte0 (out_frame_byte0),
    .out_frame_byte1 (out_frame_byte1),
    .out_frame_byte2 (out_frame_byte2),
    .out_frame_byte3 (out_frame_byte3),
    .out_is_repeat   (out_is_repeat)
  );

  irpw_frame_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_period_ticks (in_period_ticks),
    .in_low_ticks    (in_low_ticks),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_byte0 (out_frame_byte0),
    .out_frame_byte1 (out_frame_byte1),
    .out_frame_byte2 (out_frame_byte2),
    .out_frame_byte3 (out_frame_byte3),
    .out_is_repeat   (out_is_repeat),
    .mismatches      (mismatches),
    .frames_pending  (frames_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Picks a value in [lo, hi], landing on either edge one time in eight.
  function automatic logic [15:0] pick(input int lo, input int hi);
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0:       return 16'(lo);
      1:       return 16'(hi);
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  // Presents one pulse beat after a random gap and returns at the clock edge
  // that accepts it. With no gap, valid simply stays high into the next beat,
  // so valid never gets two assignments in the same time step.
  task automatic send_pulse(input logic [15:0] period, input logic [15:0] low);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_period_ticks <= period;
    in_low_ticks    <= low;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_leader();
    send_pulse(pick(LEAD_PER_MIN, LEAD_PER_MAX), pick(LEAD_LOW_MIN, LEAD_LOW_MAX));
    pulses_sent++;
  endtask

  task automatic send_repeat();
    send_pulse(pick(RPT_PER_MIN, RPT_PER_MAX), pick(LEAD_LOW_MIN, LEAD_LOW_MAX));
    pulses_sent++;
  endtask

  task automatic send_bit();
    logic [15:0] period;
    if ($urandom_range(0, 1))
      period = pick(ONE_PER_MIN, ONE_PER_MAX);
    else
      period = pick(ZERO_PER_MIN, ZERO_PER_MAX);
    send_pulse(period, pick(BIT_LOW_MIN, BIT_LOW_MAX));
    pulses_sent++;
  endtask

  // A pulse that falls outside the bit windows in one way or another; a low
  // time above the bit window also covers a leader arriving mid-frame.
  task automatic send_bad_bit();
    case ($urandom_range(0, 3))
      0: send_pulse(pick(ZERO_PER_MIN, ONE_PER_MAX), pick(0, BIT_LOW_MIN - 1));
      1: send_pulse(pick(0, 65535), pick(BIT_LOW_MAX + 1, 65535));
      2: send_pulse(pick(0, ZERO_PER_MIN - 1), pick(BIT_LOW_MIN, BIT_LOW_MAX));
      default: send_pulse(pick(ONE_PER_MAX + 1, 65535), pick(BIT_LOW_MIN, BIT_LOW_MAX));
    endcase
    pulses_sent++;
  endtask

  task automatic send_frame();
    send_leader();
    repeat (32) send_bit();
  endtask

  // Leaves the input idle and waits until every expected frame has come out,
  // then a few more cycles for pulses that produce nothing.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_threshold(input logic [3:0] value);
    cfg_wr_en     <= 1'b1;
    cfg_wr_data   <= value;
    threshold_now  = value;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
  endtask

  // The result side waits a random number of cycles before each result beat,
  // holding stall high meanwhile, then takes the beat as soon as it shows up.
  initial begin : result_pacing
    int hold;
    out_stall <= 1'b0;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int phase;
    int phase_end;
    int count;
    logic [3:0] phase_threshold [NUM_PHASES];

    phase_threshold[0] = RPT_THR_RESET;
    phase_threshold[1] = 4'd15;
    phase_threshold[2] = 4'd0;
    phase_threshold[3] = 4'd1;
    phase_threshold[4] = 4'($urandom_range(0, 15));
    phase_threshold[5] = 4'd7;

    pulses_sent      = 0;
    no_idle          = 1'b0;
    threshold_now    = RPT_THR_RESET;
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_valid        <= 1'b0;
    in_period_ticks <= '0;
    in_low_ticks    <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A threshold of zero lets the second repeat pulse already
    // re-emit the last frame, which is still all zeros at this point.
    write_threshold(4'd0);
    send_pulse(16'd0, 16'd0);             // discarded first pulse
    send_pulse(RPT_PER_MIN, LEAD_LOW_MIN);  // repeat count becomes one
    send_pulse(RPT_PER_MAX, LEAD_LOW_MAX);  // re-emits the empty last frame
    send_pulse(16'd54000, LEAD_LOW_MIN - 16'd1);  // idle pulses that are ignored
    send_pulse(16'd54000, LEAD_LOW_MAX + 16'd1);
    send_pulse(RPT_PER_MIN - 16'd1, 16'd30000);
    send_pulse(LEAD_PER_MAX + 16'd1, 16'd30000);
    send_pulse(LEAD_PER_MIN, LEAD_LOW_MIN);       // leader at its lower edges
    send_pulse(ONE_PER_MAX, BIT_LOW_MIN);         // bit window edges
    send_pulse(ZERO_PER_MIN, BIT_LOW_MAX);
    send_pulse(ONE_PER_MIN, BIT_LOW_MAX);
    send_pulse(ZERO_PER_MAX, BIT_LOW_MIN);
    send_pulse(ONE_PER_MAX + 16'd1, 16'd2000);    // abort, partial bits left behind
    send_pulse(16'd5000, 16'd2000);               // bit pulse while idle is ignored
    send_pulse(LEAD_PER_MAX, LEAD_LOW_MAX);       // leader clears the partial bits
    send_pulse(16'd5000, BIT_LOW_MIN - 16'd1);    // abort on a short low time
    send_pulse(16'd54000, 16'd34000);
    send_pulse(ZERO_PER_MIN - 16'd1, 16'd2000);   // abort on a short period
    send_pulse(16'd54000, 16'd34000);
    send_pulse(16'd5000, BIT_LOW_MAX + 16'd1);    // abort on a long low time
    send_pulse(16'd44000, 16'd34000);             // the leader cleared the count
    send_pulse(16'd44000, 16'd34000);
    send_pulse(16'hFFFF, 16'hFFFF);

    // Random phases. Well-formed frames and repeat runs dominate so that the
    // byte assembly and the repeat counter are exercised over and over.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      write_threshold(phase_threshold[phase]);
      phase_end = pulses_sent + PHASE_PULSES;
      while (pulses_sent < phase_end) begin
        no_idle = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            send_frame();
            if ($urandom_range(0, 1)) begin
              count = $urandom_range(0, threshold_now + 4);
              repeat (count) send_repeat();
            end
          end
          6: begin
            send_leader();
            count = $urandom_range(0, 31);
            repeat (count) send_bit();
            send_bad_bit();
          end
          7: begin
            count = $urandom_range(1, threshold_now + 4);
            repeat (count) send_repeat();
          end
          default: begin
            count = $urandom_range(1, 3);
            repeat (count) send_pulse(16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)));
          end
        endcase
      end
    end

    no_idle = 1'b0;
    settle();
    if (mismatches == 0)
      $display("ir_pulse_width_frame_decoder_core_test passed");
    else
      $display("ir_pulse_width_frame_decoder_core_test failed");
    $finish;
  end

  // Guards against a hang, for example a result that never arrives.
  initial begin : watchdog
    #(RUN_LIMIT);
    $display("ir_pulse_width_frame_decoder_core_test failed");
    $finish;
  end

endmodule
